FILE: sv/tfml_pkg.sv
// Package for the tree fire mortality logistic unit: types, coefficients,
// status codes and the elaboration-time exp and sigmoid tables.
// Depends on nothing; used by tfml_term and tree_fire_mortality_logistic_unit.
`timescale 1ns / 1ps
`default_nettype none
package tfml_pkg;

  localparam int unsigned SIGMOID_TABLE_DEPTH = 256;
  localparam int unsigned SIG_IDX_W = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int unsigned SIG_DEPTH_W = $clog2(SIGMOID_TABLE_DEPTH + 1);
  localparam int unsigned NUM_TERMS = 8;
  localparam int unsigned Z_W = 36;
  localparam int unsigned ABS_W = 35;
  localparam int unsigned POS_W = ABS_W + SIG_DEPTH_W;
  localparam int unsigned BARK_ENTRIES = 64;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned EXP_M1_Q30 = 64'd395007542;
  localparam logic [30:0] SIG_ONE = 31'(ONE_Q30);

  localparam logic [16:0] TERM_DIV = 17'd78125;
  localparam logic [30:0] TERM_RECIP = 31'((64'd1 << 47) / 64'd78125);
  localparam logic [63:0] HALF_NARROW = 64'd5000000;
  localparam logic [63:0] HALF_WIDE = 64'd5000000 << 10;
  localparam logic [NUM_TERMS-1:0] LANE_WIDE = 8'b1000_1000;

  localparam logic [16:0] SPRUCE_FLOOR = 17'd52429;
  localparam logic [16:0] SMALL_LIMIT = 17'd7;
  localparam logic [16:0] SAT_MAX = 17'd65535;

  localparam logic [4:0] EQN_1 = 5'd1;
  localparam logic [4:0] EQN_3 = 5'd3;
  localparam logic [4:0] EQN_5 = 5'd5;
  localparam logic [4:0] EQN_10 = 5'd10;
  localparam logic [4:0] EQN_11 = 5'd11;
  localparam logic [4:0] EQN_12 = 5'd12;
  localparam logic [4:0] EQN_14 = 5'd14;
  localparam logic [4:0] EQN_15 = 5'd15;
  localparam logic [4:0] EQN_16 = 5'd16;
  localparam logic [4:0] EQN_17 = 5'd17;
  localparam logic [4:0] EQN_18 = 5'd18;
  localparam logic [4:0] EQN_19 = 5'd19;
  localparam logic [4:0] EQN_20 = 5'd20;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_NO_SCORCH,
    STATUS_BAD_EQN
  } status_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] trunk_diameter;
    logic [11:0] bark_thickness;
    logic [15:0] scorch_height;
    logic [10:0] crown_length_scorched;
    logic [10:0] crown_volume_scorched;
  } tfml_in_t;

  typedef struct packed {
    logic [15:0] mortality;
    status_t     status;
  } tfml_out_t;

  typedef struct packed {
    logic                        valid;
    logic                        negate;
    logic                        use_volume;
    logic [NUM_TERMS-1:0]        cneg;
    logic [NUM_TERMS-1:0][29:0]  cmag;
  } coef_t;

  typedef struct packed {
    logic no_scorch;
    logic bad_eqn;
    logic floor_eqn;
    logic negate;
  } meta_t;

  typedef struct packed {
    logic        neg;
    logic        wide;
    logic [29:0] mag;
    logic [32:0] x;
  } term_in_t;

  typedef logic [30:0] sig_tab_t [SIGMOID_TABLE_DEPTH];
  typedef logic [30:0] bark_tab_t [BARK_ENTRIES];

  function automatic coef_t mk_coef(logic neg, logic vol, longint c0, longint c1,
                                    longint c2, longint c3, longint c4, longint c5,
                                    longint c6, longint c7);
    coef_t  e;
    longint c [NUM_TERMS];
    c[0] = c0; c[1] = c1; c[2] = c2; c[3] = c3;
    c[4] = c4; c[5] = c5; c[6] = c6; c[7] = c7;
    e.valid = 1'b1;
    e.negate = neg;
    e.use_volume = vol;
    for (int i = 0; i < NUM_TERMS; i++) begin
      e.cneg[i] = (c[i] < 0);
      e.cmag[i] = 30'((c[i] < 0) ? -c[i] : c[i]);
    end
    return e;
  endfunction

  function automatic coef_t eqn_lookup(logic [4:0] kind);
    coef_t e;
    case (kind)
      EQN_1, EQN_3: begin
        e = mk_coef(1'b1, 1'b1, -19410000, 0, -53500000, 0, 0, 0, 0, 63160000);
      end
      EQN_5: begin
        e = mk_coef(1'b1, 1'b1, 1690000, 0, -348000000, 0, 0, 130454400, 934965872, 0);
      end
      EQN_10: begin
        e = mk_coef(1'b0, 1'b0, -35083000, 95600000, -184000000, 170000000, 0, 0, 0, 0);
      end
      EQN_11: begin
        e = mk_coef(1'b0, 1'b1, -16950000, 207100000, -470000000, 350000000, 0, 0, 0, 0);
      end
      EQN_12: begin
        e = mk_coef(1'b0, 1'b0, -42466000, 0, 0, 71720000, 0, 0, 0, 0);
      end
      EQN_14: begin
        e = mk_coef(1'b0, 1'b1, -16594000, 32700000, 0, 0, -1242060, 0, 0, 0);
      end
      EQN_15: begin
        e = mk_coef(1'b0, 1'b1, 845000, 44500000, 0, 0, 0, 0, 0, 0);
      end
      EQN_16: begin
        e = mk_coef(1'b0, 1'b0, -23085000, 0, 0, 40590000, 0, 0, 0, 0);
      end
      EQN_17: begin
        e = mk_coef(1'b0, 1'b1, -3268000, 138700000, -330000000, 250000000, -675640,
                    0, 0, 0);
      end
      EQN_18: begin
        e = mk_coef(1'b0, 1'b0, -20588000, 0, 81400000, 0, 0, 0, 0, 0);
      end
      EQN_19: begin
        e = mk_coef(1'b0, 1'b1, -27103000, 0, 0, 40930000, 0, 0, 0, 0);
      end
      EQN_20: begin
        e = mk_coef(1'b0, 1'b1, -20346000, 90600000, -220000000, 190000000, 0, 0, 0, 0);
      end
      default: begin
        e = '0;
      end
    endcase
    return e;
  endfunction

  // The functions below only build constant tables at elaboration.
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned rm;
    q = 0;
    rm = 0;
    for (int i = 63; i >= 0; i--) begin
      rm = {rm[62:0], num[i]};
      if (rm >= den) begin
        rm = rm - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned exp_neg_q30(longint unsigned x);
    longint unsigned n;
    longint unsigned r;
    longint unsigned t;
    longint unsigned res;
    longint          s;
    int              k;
    n = x >> 20;
    r = x & 64'hFFFFF;
    s = longint'(ONE_Q30);
    t = ONE_Q30;
    if (n >= 40) begin
      return 0;
    end
    for (k = 1; k <= 14; k++) begin
      t = div_u64((t * r) >> 20, longint'(k));
      if (k[0]) begin
        s = s - longint'(t);
      end else begin
        s = s + longint'(t);
      end
    end
    res = longint'(s);
    while (n > 0) begin
      res = (res * EXP_M1_Q30) >> 30;
      n = n - 1;
    end
    return res;
  endfunction

  function automatic longint unsigned sig_entry(longint unsigned k);
    longint unsigned x;
    x = (k << 24) / SIGMOID_TABLE_DEPTH;
    return div_u64(ONE_Q30 << 30, ONE_Q30 + exp_neg_q30(x));
  endfunction

  function automatic sig_tab_t build_sig(int offset);
    sig_tab_t tab;
    for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin
      tab[i] = 31'(sig_entry(longint'(i + offset)));
    end
    return tab;
  endfunction

  function automatic bark_tab_t build_bark(int offset);
    bark_tab_t tab;
    for (int i = 0; i < BARK_ENTRIES; i++) begin
      tab[i] = 31'(exp_neg_q30(longint'(i + offset) << 16));
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_LO = build_sig(0);
  localparam sig_tab_t SIG_HI = build_sig(1);
  localparam bark_tab_t BARK_LO = build_bark(0);
  localparam bark_tab_t BARK_HI = build_bark(1);

endpackage
`default_nettype wire

FILE: sv/tree_fire_mortality_logistic_unit.sv
// Top level of the tree fire mortality logistic unit.
// Depends on tfml_pkg and instantiates eight tfml_term lanes.
//
// Usage:
// A tree record is transferred on in_item at a rising edge where start is high
// and busy is low. busy never rises, so a record may be offered in every cycle.
// Each record yields exactly one result on out_item, marked by out_strobe for a
// single cycle; it is transferred at the edge that ends that cycle.
// Throughput is one record per cycle. The pipeline has three operand stages,
// six stages in each term lane (product, rounding, reciprocal multiply,
// quotient, back multiply, correction), two adder tree stages and five
// sigmoid and output stages.
// The receiver cannot hold results off, so nothing ever waits.
// Synchronous reset drops every record in flight; no result appears for them.
// Status 1 reports a zero scorch height and status 2 an unknown equation
// number; both give a mortality of zero.
`timescale 1ns / 1ps
`default_nettype none
module tree_fire_mortality_logistic_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire tfml_pkg::tfml_in_t   in_item,
  output logic                      busy,
  output logic                      out_strobe,
  output tfml_pkg::tfml_out_t       out_item
);

  localparam int unsigned PIPE_REGS = 16;
  localparam int unsigned META_REGS = 14;

  logic [PIPE_REGS-1:0] vld_r;
  tfml_pkg::meta_t      meta_r [META_REGS];

  tfml_pkg::tfml_in_t in_r;

  tfml_pkg::coef_t coef1_r;
  logic [10:0] f1_r;
  logic [21:0] f2_1_r;
  logic [11:0] b1_r;
  logic [23:0] b2_1_r;
  logic [15:0] d1_r;
  logic [30:0] be0_1_r;
  logic [36:0] bp1_r;

  tfml_pkg::term_in_t term_in_r [tfml_pkg::NUM_TERMS];
  logic signed [31:0] term_w [tfml_pkg::NUM_TERMS];

  logic signed [tfml_pkg::Z_W-1:0] sum4_r [4];
  logic signed [tfml_pkg::Z_W-1:0] z_r;
  logic [tfml_pkg::POS_W-1:0] pos_r;
  logic        eneg_c_r, eneg_d_r, eneg_e_r;
  logic [30:0] e0_d_r, e0_e_r;
  logic [30:0] diff_d_r;
  logic [19:0] fr_d_r;
  logic [50:0] prod_e_r;
  logic [16:0] m_f_r;
  tfml_pkg::tfml_out_t out_r;

  tfml_pkg::coef_t coef_nxt;
  tfml_pkg::meta_t meta_nxt;
  logic [10:0] f_nxt;
  logic [5:0]  bidx;
  logic [30:0] be0, bdiff;
  logic [32:0] f3_nxt;
  logic [30:0] bark_exp;
  logic [32:0] x_nxt [tfml_pkg::NUM_TERMS];
  logic signed [tfml_pkg::Z_W-1:0] sum4_nxt [4];
  logic signed [tfml_pkg::Z_W-1:0] z_nxt;
  logic        zlt, zgt, eneg_nxt;
  logic [tfml_pkg::ABS_W-1:0] abs_z;
  logic [tfml_pkg::POS_W-1:0] pos_nxt;
  logic [tfml_pkg::POS_W-25:0] sidx;
  logic        sat;
  logic [tfml_pkg::SIG_IDX_W-1:0] tidx;
  logic [30:0] e0_nxt, diff_nxt;
  logic [30:0] s_val, sig_val;
  logic [16:0] m_nxt;
  logic [16:0] m_fl, m_sat, m_fin;
  tfml_pkg::tfml_out_t out_nxt;

  assign busy = 1'b0;

  // Operand stage: coefficient lookup, squares and bark exp interpolation.
  always_comb begin
    coef_nxt = tfml_pkg::eqn_lookup(in_r.kind);
    f_nxt = coef_nxt.use_volume ? in_r.crown_volume_scorched : in_r.crown_length_scorched;
    bidx  = in_r.bark_thickness[11:6];
    be0   = tfml_pkg::BARK_LO[bidx];
    bdiff = be0 - tfml_pkg::BARK_HI[bidx];
    meta_nxt.no_scorch = (in_r.scorch_height == 16'd0);
    meta_nxt.bad_eqn   = !coef_nxt.valid;
    meta_nxt.floor_eqn = (in_r.kind == tfml_pkg::EQN_3);
    meta_nxt.negate    = coef_nxt.negate;
  end

  // Second operand stage: cube and the operands of all eight lanes.
  always_comb begin
    f3_nxt   = 33'(f2_1_r) * 33'(f1_r);
    bark_exp = be0_1_r - 31'(bp1_r >> 6);
    x_nxt[0] = 33'(64'd1 << 20);
    x_nxt[1] = 33'({f1_r, 10'd0});
    x_nxt[2] = 33'(f2_1_r);
    x_nxt[3] = f3_nxt;
    x_nxt[4] = 33'({d1_r, 14'd0});
    x_nxt[5] = 33'({b1_r, 10'd0});
    x_nxt[6] = 33'(b2_1_r);
    x_nxt[7] = 33'(tfml_pkg::SIG_ONE - bark_exp);
  end

  for (genvar i = 0; i < tfml_pkg::NUM_TERMS; i++) begin : g_term
    tfml_term u_term (
      .clk      (clk),
      .term_in  (term_in_r[i]),
      .term_out (term_w[i])
    );
  end

  // Adder tree, sign handling and sigmoid interpolation.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum4_nxt[i] = tfml_pkg::Z_W'(term_w[2*i]) + tfml_pkg::Z_W'(term_w[2*i+1]);
    end
    z_nxt = sum4_r[0] + sum4_r[1] + sum4_r[2] + sum4_r[3];
    zlt = z_r[tfml_pkg::Z_W-1];
    zgt = !zlt && (z_r != '0);
    eneg_nxt = meta_r[9].negate ? zgt : zlt;
    abs_z = tfml_pkg::ABS_W'(zlt ? -z_r : z_r);
    pos_nxt = tfml_pkg::POS_W'(abs_z) * tfml_pkg::POS_W'(tfml_pkg::SIGMOID_TABLE_DEPTH);
    sidx = pos_r[tfml_pkg::POS_W-1:24];
    sat  = (sidx >= (tfml_pkg::POS_W-24)'(tfml_pkg::SIGMOID_TABLE_DEPTH));
    tidx = sidx[tfml_pkg::SIG_IDX_W-1:0];
    if (sat) begin
      e0_nxt   = tfml_pkg::SIG_HI[tfml_pkg::SIGMOID_TABLE_DEPTH-1];
      diff_nxt = '0;
    end else begin
      e0_nxt   = tfml_pkg::SIG_LO[tidx];
      diff_nxt = tfml_pkg::SIG_HI[tidx] - tfml_pkg::SIG_LO[tidx];
    end
    s_val   = e0_e_r + 31'(prod_e_r >> 20);
    sig_val = eneg_e_r ? (tfml_pkg::SIG_ONE - s_val) : s_val;
    m_nxt   = 17'((32'(sig_val) + 32'd8192) >> 14);
  end

  // Result stage: floor, saturation, small cutoff and status.
  always_comb begin
    m_fl  = (meta_r[13].floor_eqn && (m_f_r < tfml_pkg::SPRUCE_FLOOR)) ?
            tfml_pkg::SPRUCE_FLOOR : m_f_r;
    m_sat = (m_fl > tfml_pkg::SAT_MAX) ? tfml_pkg::SAT_MAX : m_fl;
    m_fin = (m_sat < tfml_pkg::SMALL_LIMIT) ? 17'd0 : m_sat;
    if (meta_r[13].no_scorch) begin
      out_nxt.mortality = 16'd0;
      out_nxt.status    = tfml_pkg::STATUS_NO_SCORCH;
    end else if (meta_r[13].bad_eqn) begin
      out_nxt.mortality = 16'd0;
      out_nxt.status    = tfml_pkg::STATUS_BAD_EQN;
    end else begin
      out_nxt.mortality = m_fin[15:0];
      out_nxt.status    = tfml_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_REGS-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_item;
    coef1_r <= coef_nxt;
    f1_r    <= f_nxt;
    f2_1_r  <= 22'(f_nxt) * 22'(f_nxt);
    b1_r    <= in_r.bark_thickness;
    b2_1_r  <= 24'(in_r.bark_thickness) * 24'(in_r.bark_thickness);
    d1_r    <= in_r.trunk_diameter;
    be0_1_r <= be0;
    bp1_r   <= 37'(bdiff) * 37'(in_r.bark_thickness[5:0]);
    meta_r[0] <= meta_nxt;
    for (int j = 1; j < META_REGS; j++) begin
      meta_r[j] <= meta_r[j-1];
    end
    for (int i = 0; i < tfml_pkg::NUM_TERMS; i++) begin
      term_in_r[i].neg  <= coef1_r.cneg[i];
      term_in_r[i].wide <= tfml_pkg::LANE_WIDE[i];
      term_in_r[i].mag  <= coef1_r.cmag[i];
      term_in_r[i].x    <= x_nxt[i];
    end
    for (int i = 0; i < 4; i++) begin
      sum4_r[i] <= sum4_nxt[i];
    end
    z_r      <= z_nxt;
    pos_r    <= pos_nxt;
    eneg_c_r <= eneg_nxt;
    e0_d_r   <= e0_nxt;
    diff_d_r <= diff_nxt;
    fr_d_r   <= pos_r[23:4];
    eneg_d_r <= eneg_c_r;
    prod_e_r <= 51'(diff_d_r) * 51'(fr_d_r);
    e0_e_r   <= e0_d_r;
    eneg_e_r <= eneg_d_r;
    m_f_r    <= m_nxt;
    out_r    <= out_nxt;
  end

  assign out_strobe = vld_r[PIPE_REGS-1];
  assign out_item   = out_r;

`ifndef SYNTHESIS
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##16 out_strobe)
    else $error("transfer did not produce a result after 16 cycles");

  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, 16))
    else $error("result without a matching input transfer");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.status != tfml_pkg::STATUS_OK |-> out_item.mortality == 16'd0)
    else $error("nonzero mortality with an error status");

  a_small_cut: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_item.mortality == 16'd0 ||
                   out_item.mortality >= tfml_pkg::SMALL_LIMIT[15:0])
    else $error("mortality below the small result limit");

  a_floor_lane: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[14] && meta_r[13].floor_eqn && !meta_r[13].no_scorch |=>
      out_item.mortality >= tfml_pkg::SPRUCE_FLOOR[15:0])
    else $error("floored equation gave a result below its floor");
`endif

endmodule
`default_nettype wire

FILE: sv/tfml_term.sv
// One term of the linear predictor: coefficient times operand, rounded to Q20.
// Six register stages; division by 1e7 is a reciprocal multiply with a correction.
// Depends on tfml_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tfml_term (
  input  wire logic               clk,
  input  wire tfml_pkg::term_in_t term_in,
  output logic signed [31:0]      term_out
);

  logic [62:0] mag_r;
  logic        neg1_r, wide1_r;
  logic [46:0] m2_r;
  logic        neg2_r;
  logic [54:0] pl_r;
  logic [53:0] ph_r;
  logic [46:0] m3_r;
  logic        neg3_r;
  logic [30:0] q0_4_r;
  logic [46:0] m4_r;
  logic        neg4_r;
  logic [47:0] qd_r;
  logic [30:0] q0_5_r;
  logic [46:0] m5_r;
  logic        neg5_r;
  logic signed [31:0] term_r;

  logic [62:0] mag_nxt;
  logic [63:0] rnd_sum;
  logic [46:0] m2_nxt;
  logic [54:0] pl_nxt;
  logic [53:0] ph_nxt;
  logic [77:0] psum;
  logic [47:0] qd_nxt;
  logic [17:0] rem;
  logic [31:0] q_fix;
  logic signed [31:0] term_nxt;

  always_comb begin
    mag_nxt = 63'(term_in.mag) * 63'(term_in.x);
    rnd_sum = {1'b0, mag_r} + (wide1_r ? tfml_pkg::HALF_WIDE : tfml_pkg::HALF_NARROW);
    m2_nxt  = wide1_r ? 47'(rnd_sum >> 17) : 47'(rnd_sum >> 7);
    pl_nxt  = 55'(m2_r[23:0]) * 55'(tfml_pkg::TERM_RECIP);
    ph_nxt  = 54'(m2_r[46:24]) * 54'(tfml_pkg::TERM_RECIP);
    psum    = {ph_r, 24'd0} + 78'(pl_r);
    qd_nxt  = 48'(q0_4_r) * 48'(tfml_pkg::TERM_DIV);
    rem     = m5_r[17:0] - qd_r[17:0];
    q_fix   = 32'(q0_5_r) + ((rem >= 18'(tfml_pkg::TERM_DIV)) ? 32'd1 : 32'd0);
    term_nxt = neg5_r ? -$signed(q_fix) : $signed(q_fix);
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    neg1_r  <= term_in.neg;
    wide1_r <= term_in.wide;
    m2_r    <= m2_nxt;
    neg2_r  <= neg1_r;
    pl_r    <= pl_nxt;
    ph_r    <= ph_nxt;
    m3_r    <= m2_r;
    neg3_r  <= neg2_r;
    q0_4_r  <= psum[77:47];
    m4_r    <= m3_r;
    neg4_r  <= neg3_r;
    qd_r    <= qd_nxt;
    q0_5_r  <= q0_4_r;
    m5_r    <= m4_r;
    neg5_r  <= neg4_r;
    term_r  <= term_nxt;
  end

  assign term_out = term_r;

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for the tree fire mortality logistic unit: directed table, then random records.
// Results are checked against known table values or a behavioral mortality predictor here.
// Depends on tfml_pkg and tree_fire_mortality_logistic_unit.
`timescale 1ns / 1ps
module tb_top;
  import tfml_pkg::*;

  localparam int LATENCY = 16;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int DIR_N = 22;

  typedef struct {
    logic [4:0]  kind;
    logic [15:0] d;
    logic [11:0] b;
    logic [15:0] sh;
    logic [10:0] cl;
    logic [10:0] cv;
    bit          known;
    logic [15:0] mort;
    status_t     st;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  tfml_in_t in_item = '0;
  logic busy;
  logic out_strobe;
  tfml_out_t out_item;

  tfml_out_t mortality_q[$];
  int errors = 0;
  int n_results = 0;
  int n_sent = 0;
  longint cycles = 0;
  int kind_hits[32];

  tree_fire_mortality_logistic_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item),
    .busy(busy), .out_strobe(out_strobe), .out_item(out_item)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint unsigned exp_minus(longint unsigned x);
    longint unsigned n;
    longint unsigned r;
    longint unsigned t;
    longint unsigned res;
    longint s;
    n = x >> 20;
    r = x & 64'hFFFFF;
    s = 64'd1 << 30;
    t = 64'd1 << 30;
    if (n >= 40) return 0;
    for (int k = 1; k <= 14; k++) begin
      t = ((t * r) >> 20) / longint'(k);
      if (k % 2 == 1) s = s - longint'(t);
      else s = s + longint'(t);
    end
    res = s;
    for (longint unsigned i = 0; i < n; i++) res = (res * 64'd395007542) >> 30;
    return res;
  endfunction

  function automatic longint unsigned logistic_node(longint unsigned k);
    longint unsigned x;
    x = (k << 24) / SIGMOID_TABLE_DEPTH;
    return (64'd1 << 60) / ((64'd1 << 30) + exp_minus(x));
  endfunction

  function automatic longint unsigned logistic(longint z);
    longint unsigned a;
    longint unsigned p;
    longint unsigned i;
    longint unsigned fr;
    longint unsigned s;
    longint unsigned e0;
    longint unsigned e1;
    a = (z < 0) ? -z : z;
    p = (a * SIGMOID_TABLE_DEPTH) >> 4;
    i = p >> 20;
    fr = p & 64'hFFFFF;
    if (i >= SIGMOID_TABLE_DEPTH) s = logistic_node(SIGMOID_TABLE_DEPTH);
    else begin
      e0 = logistic_node(i);
      e1 = logistic_node(i + 1);
      s = e0 + (((e1 - e0) * fr) >> 20);
    end
    return (z < 0) ? (64'd1 << 30) - s : s;
  endfunction

  function automatic longint unsigned bark_decay(longint unsigned b);
    longint unsigned i;
    longint unsigned e0;
    longint unsigned e1;
    i = (b >> 6) & 63;
    e0 = exp_minus(i << 16);
    e1 = exp_minus((i + 1) << 16);
    return e0 - (((e0 - e1) * (b & 63)) >> 6);
  endfunction

  function automatic longint scaled_term(longint c, longint unsigned x, int extra);
    longint unsigned mag;
    longint unsigned den;
    longint unsigned q;
    mag = ((c < 0) ? -c : c) * x;
    den = 64'd10000000 << extra;
    q = (mag + den / 2) / den;
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic tfml_out_t predict_mortality(tfml_in_t r);
    tfml_out_t o;
    longint c[8];
    bit neg;
    bit vol;
    bit ok;
    longint unsigned f;
    longint unsigned m;
    longint z;
    o.mortality = '0;
    neg = 1'b0;
    vol = 1'b0;
    ok = 1'b1;
    for (int i = 0; i < 8; i++) c[i] = 0;
    case (r.kind)
      EQN_1, EQN_3: begin
        neg = 1; vol = 1; c[0] = -19410000; c[2] = -53500000; c[7] = 63160000;
      end
      EQN_5: begin
        neg = 1; vol = 1; c[0] = 1690000; c[2] = -348000000; c[5] = 130454400;
        c[6] = 934965872;
      end
      EQN_10: begin
        c[0] = -35083000; c[1] = 95600000; c[2] = -184000000; c[3] = 170000000;
      end
      EQN_11: begin
        vol = 1; c[0] = -16950000; c[1] = 207100000; c[2] = -470000000;
        c[3] = 350000000;
      end
      EQN_12: begin
        c[0] = -42466000; c[3] = 71720000;
      end
      EQN_14: begin
        vol = 1; c[0] = -16594000; c[1] = 32700000; c[4] = -1242060;
      end
      EQN_15: begin
        vol = 1; c[0] = 845000; c[1] = 44500000;
      end
      EQN_16: begin
        c[0] = -23085000; c[3] = 40590000;
      end
      EQN_17: begin
        vol = 1; c[0] = -3268000; c[1] = 138700000; c[2] = -330000000;
        c[3] = 250000000; c[4] = -675640;
      end
      EQN_18: begin
        c[0] = -20588000; c[2] = 81400000;
      end
      EQN_19: begin
        vol = 1; c[0] = -27103000; c[3] = 40930000;
      end
      EQN_20: begin
        vol = 1; c[0] = -20346000; c[1] = 90600000; c[2] = -220000000;
        c[3] = 190000000;
      end
      default: ok = 1'b0;
    endcase
    if (r.scorch_height == 0) begin
      o.status = STATUS_NO_SCORCH;
      return o;
    end
    if (!ok) begin
      o.status = STATUS_BAD_EQN;
      return o;
    end
    f = vol ? r.crown_volume_scorched : r.crown_length_scorched;
    z = scaled_term(c[0], 64'd1 << 20, 0) + scaled_term(c[1], f << 10, 0)
      + scaled_term(c[2], f * f, 0) + scaled_term(c[3], f * f * f, 10)
      + scaled_term(c[4], longint'(r.trunk_diameter) << 14, 0)
      + scaled_term(c[5], longint'(r.bark_thickness) << 10, 0)
      + scaled_term(c[6], longint'(r.bark_thickness) * r.bark_thickness, 0)
      + scaled_term(c[7], (64'd1 << 30) - bark_decay(r.bark_thickness), 10);
    if (neg) z = -z;
    m = (logistic(z) + 8192) >> 14;
    if (r.kind == EQN_3 && m < 52429) m = 52429;
    if (m > 65535) m = 65535;
    if (m < 7) m = 0;
    o.mortality = m[15:0];
    o.status = STATUS_OK;
    return o;
  endfunction

  always @(posedge clk) begin
    tfml_out_t exp_r;
    if (rst_n && out_strobe) begin
      n_results++;
      if (mortality_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, out_item);
      end else begin
        exp_r = mortality_q.pop_front();
        if (out_item.mortality !== exp_r.mortality || out_item.status !== exp_r.status) begin
          errors++;
          $display("%0t: mismatch expected mort=%0d st=%0d actual mort=%0d st=%0d",
                   $time, exp_r.mortality, exp_r.status, out_item.mortality,
                   out_item.status);
        end
      end
    end
  end

  task automatic idle_cycles(int n);
    for (int i = 0; i < n; i++) @(negedge clk);
  endtask

  task automatic send_record(tfml_in_t r, tfml_out_t e);
    start <= 1'b1;
    in_item <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    mortality_q.push_back(e);
    kind_hits[r.kind]++;
    n_sent++;
    @(negedge clk);
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic tfml_in_t random_record();
    tfml_in_t r;
    int p;
    logic [4:0] valid_kinds[13] = '{EQN_1, EQN_3, EQN_5, EQN_10, EQN_11, EQN_12,
                                    EQN_14, EQN_15, EQN_16, EQN_17, EQN_18, EQN_19,
                                    EQN_20};
    r.kind = ($urandom_range(0, 9) == 0) ? 5'($urandom) : valid_kinds[$urandom_range(0, 12)];
    r.trunk_diameter = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3200));
    r.bark_thickness = 12'($urandom);
    r.scorch_height = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom);
    p = $urandom_range(0, 9);
    r.crown_length_scorched = (p == 0) ? 11'($urandom) : 11'($urandom_range(0, 1024));
    p = $urandom_range(0, 9);
    r.crown_volume_scorched = (p == 0) ? 11'($urandom) : 11'($urandom_range(0, 1024));
    return r;
  endfunction

  dir_row_t dir_tab[DIR_N] = '{
    '{EQN_1,  16'd0,     12'd0,    16'd0,     11'd0,    11'd0,    1, 16'd0, STATUS_NO_SCORCH},
    '{5'd31,  16'd0,     12'd0,    16'd0,     11'd0,    11'd0,    1, 16'd0, STATUS_NO_SCORCH},
    '{5'd0,   16'd100,   12'd100,  16'd1,     11'd512,  11'd512,  1, 16'd0, STATUS_BAD_EQN},
    '{5'd2,   16'd100,   12'd100,  16'd1,     11'd512,  11'd512,  1, 16'd0, STATUS_BAD_EQN},
    '{5'd13,  16'hFFFF,  12'hFFF,  16'hFFFF,  11'h7FF,  11'h7FF,  1, 16'd0, STATUS_BAD_EQN},
    '{5'd31,  16'hFFFF,  12'hFFF,  16'hFFFF,  11'h7FF,  11'h7FF,  1, 16'd0, STATUS_BAD_EQN},
    '{EQN_1,  16'd640,   12'd0,    16'd160,   11'd0,    11'd1024, 0, 16'd0, STATUS_OK},
    '{EQN_3,  16'd640,   12'd4095, 16'd160,   11'd0,    11'd0,    0, 16'd0, STATUS_OK},
    '{EQN_3,  16'd640,   12'd0,    16'd160,   11'd0,    11'd1024, 0, 16'd0, STATUS_OK},
    '{EQN_5,  16'd640,   12'd4095, 16'd160,   11'd0,    11'd0,    0, 16'd0, STATUS_OK},
    '{EQN_5,  16'd0,     12'd0,    16'd160,   11'd0,    11'h7FF,  0, 16'd0, STATUS_OK},
    '{EQN_10, 16'd640,   12'd200,  16'd160,   11'd1024, 11'd0,    0, 16'd0, STATUS_OK},
    '{EQN_11, 16'd640,   12'd200,  16'd160,   11'd0,    11'h7FF,  0, 16'd0, STATUS_OK},
    '{EQN_12, 16'd640,   12'd200,  16'd160,   11'h7FF,  11'd0,    0, 16'd0, STATUS_OK},
    '{EQN_14, 16'hFFFF,  12'd200,  16'd160,   11'd0,    11'd0,    0, 16'd0, STATUS_OK},
    '{EQN_15, 16'd640,   12'd200,  16'd1,     11'd0,    11'd1024, 0, 16'd0, STATUS_OK},
    '{EQN_16, 16'd640,   12'd200,  16'hFFFF,  11'd1024, 11'd0,    0, 16'd0, STATUS_OK},
    '{EQN_17, 16'hFFFF,  12'd200,  16'd160,   11'd0,    11'd1024, 0, 16'd0, STATUS_OK},
    '{EQN_17, 16'd0,     12'd200,  16'd160,   11'd0,    11'd0,    0, 16'd0, STATUS_OK},
    '{EQN_18, 16'd640,   12'd200,  16'd160,   11'h7FF,  11'd0,    0, 16'd0, STATUS_OK},
    '{EQN_19, 16'd640,   12'd200,  16'd160,   11'd0,    11'h7FF,  0, 16'd0, STATUS_OK},
    '{EQN_20, 16'd640,   12'd63,   16'd160,   11'd0,    11'd512,  0, 16'd0, STATUS_OK}
  };

  initial begin
    tfml_in_t r;
    tfml_out_t e;
    int drain;
    int n_bad;
    coef_t cf;
    for (int i = 0; i < 32; i++) kind_hits[i] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < DIR_N; i++) begin
      r.kind = dir_tab[i].kind;
      r.trunk_diameter = dir_tab[i].d;
      r.bark_thickness = dir_tab[i].b;
      r.scorch_height = dir_tab[i].sh;
      r.crown_length_scorched = dir_tab[i].cl;
      r.crown_volume_scorched = dir_tab[i].cv;
      if (dir_tab[i].known) begin
        e.mortality = dir_tab[i].mort;
        e.status = dir_tab[i].st;
      end else begin
        e = predict_mortality(r);
      end
      send_record(r, e);
    end
    start <= 1'b0;
    for (int i = 0; i < 1830; i++) begin
      if (i == 900) begin
        start <= 1'b0;
        while (mortality_q.size() != 0) @(negedge clk);
      end
      if (i % 200 < 40) begin
        r = random_record();
        send_record(r, predict_mortality(r));
      end else begin
        drain = pick_gap();
        if (drain > 0) begin
          start <= 1'b0;
          idle_cycles(drain);
        end
        r = random_record();
        send_record(r, predict_mortality(r));
      end
    end
    start <= 1'b0;
    while (mortality_q.size() != 0) @(negedge clk);
    idle_cycles(LATENCY + 4);
    n_bad = 0;
    for (int k = 0; k < 32; k++) begin
      cf = eqn_lookup(5'(k));
      if (!cf.valid) n_bad += kind_hits[k];
    end
    $display("Sent %0d records, checked %0d results; %0d unknown-equation, %0d spruce records.",
             n_sent, n_results, n_bad, kind_hits[3]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

FILE: tree_fire_mortality_logistic_unit.f
sv/tfml_pkg.sv
sv/tfml_term.sv
sv/tree_fire_mortality_logistic_unit.sv
sim/tb_top.sv
